### hdl/region_table_protection_check_assert.svh
// Assertion macros for the region table protection check.
// Every macro samples on clk and is disabled while rst is high.
`ifndef REGION_TABLE_PROTECTION_CHECK_ASSERT_SVH
`define REGION_TABLE_PROTECTION_CHECK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rtpc_pkg.sv
// Shared types and constants for the region table protection check.
// Used by the table memory, the scan unit and the top level.
package rtpc_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  localparam int BASE_W = 48;
  localparam int BOUND_W = 49;
  localparam int PROT_W = 3;
  localparam int PAGE_W = 49;
  localparam int LIM_W = 50;
  localparam int LEN_W = 32;
  localparam int SHIFT_W = 5;
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam int OUT_IDX_W = 6;
  localparam int SLOT_W = 6;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd12;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT = 2'd1;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_RANGE  = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_FIND   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEG_CHECK,
    ST_SEG_LIMIT,
    ST_SEG_NEXT,
    ST_SEG_TEST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [BOUND_W-1:0] bound;
    logic [PROT_W-1:0]  prot;
  } entry_t;

  typedef struct packed {
    logic             clear;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic               sel_valid;
    logic [BOUND_W-1:0] sel_bound;
    logic [PROT_W-1:0]  sel_prot;
    logic               has_next;
    logic [BASE_W-1:0]  next_base;
    logic               found;
    logic [IDX_W-1:0]   found_idx;
  } scan_res_t;

endpackage

### hdl/rtpc_table.sv
// Region table storage: one write port and one read port with registered data.
// Depends on rtpc_pkg for the entry type and the table depth.
module rtpc_table (
  input  logic                   clk,
  input  logic                   we,
  input  logic [rtpc_pkg::IDX_W-1:0] waddr,
  input  rtpc_pkg::entry_t       wdata,
  input  logic                   re,
  input  logic [rtpc_pkg::IDX_W-1:0] raddr,
  output rtpc_pkg::entry_t       rdata
);
  import rtpc_pkg::*;

  entry_t mem [MAX_REGIONS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/rtpc_scan.sv
// Shared compare unit that folds one table entry per cycle into the scan state.
// Depends on rtpc_pkg for the entry, control and result types.
module rtpc_scan (
  input  logic                     clk,
  input  logic                     rst,
  input  rtpc_pkg::scan_ctl_t      ctl,
  input  rtpc_pkg::entry_t         ent,
  input  logic [rtpc_pkg::PAGE_W-1:0] key,
  output rtpc_pkg::scan_res_t      res
);
  import rtpc_pkg::*;

  logic at_or_below;
  logic inside_entry;
  logic closer;

  assign at_or_below = {1'b0, ent.base} <= key;
  assign inside_entry = at_or_below && (key < ent.bound);
  assign closer = !res.has_next || (ent.base < res.next_base);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.sel_valid <= 1'b0;
      res.has_next <= 1'b0;
      res.found <= 1'b0;
    end else if (ctl.clear) begin
      res.sel_valid <= 1'b0;
      res.has_next <= 1'b0;
      res.found <= 1'b0;
    end else if (ctl.hit) begin
      // A later entry at or below the key takes over the selection, and
      // candidates for the next start seen before it no longer count.
      if (at_or_below) begin
        res.sel_valid <= 1'b1;
        res.has_next <= 1'b0;
        res.sel_bound <= ent.bound;
        res.sel_prot <= ent.prot;
      end else if (closer) begin
        res.has_next <= 1'b1;
        res.next_base <= ent.base;
      end
      if (!res.found && inside_entry) begin
        res.found <= 1'b1;
        res.found_idx <= ctl.idx;
      end
    end
  end

endmodule

### hdl/region_table_protection_check.sv
// Top level of the region table protection check: sequencer, registers, result.
// Depends on rtpc_pkg, rtpc_table, rtpc_scan and the assertion macro header.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_type, entry_*, query_*, required_prot
//   rsp      out        rsp_valid/rsp_ready   access_ok, page_prot, entry_found, entry_index
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A load writes the table and goes straight to the result. A lookup or find walks the first N
// table entries, N being the clamped region count. A range check walks them once for each segment
// of pages under one region, and there are at most N segments.
// The table is walked one entry per cycle through its single read port.
// Reset is synchronous; the table contents are not cleared.
// A new item is taken while the previous result still waits for rsp_ready.
module region_table_protection_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [1:0]                     req_type,
  input  logic [rtpc_pkg::SLOT_W-1:0]    entry_slot,
  input  logic [rtpc_pkg::BASE_W-1:0]    entry_start,
  input  logic [rtpc_pkg::BOUND_W-1:0]   entry_end,
  input  logic [rtpc_pkg::PROT_W-1:0]    entry_prot,
  input  logic [rtpc_pkg::BASE_W-1:0]    query_addr,
  input  logic [rtpc_pkg::LEN_W-1:0]     query_length,
  input  logic [rtpc_pkg::PROT_W-1:0]    required_prot,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic                           access_ok,
  output logic [rtpc_pkg::PROT_W-1:0]    page_prot,
  output logic                           entry_found,
  output logic [rtpc_pkg::OUT_IDX_W-1:0] entry_index,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rtpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rtpc_pkg::*;

  `include "region_table_protection_check_assert.svh"

  state_t state;
  state_t state_next;

  logic [SHIFT_W-1:0] page_shift;
  logic [COUNT_W-1:0] region_count;

  req_t              rtype;
  logic [PAGE_W-1:0] key;
  logic [PAGE_W-1:0] ep;
  logic [PROT_W-1:0] need;
  logic [LIM_W-1:0]  lim;
  logic [CNT_W-1:0]  issue_cnt;
  logic              rvalid;
  logic [IDX_W-1:0]  ridx;

  logic                 res_ok;
  logic [PROT_W-1:0]    res_prot;
  logic                 res_found;
  logic [OUT_IDX_W-1:0] res_idx;

  logic [SHIFT_W-1:0] eff_shift;
  logic [CNT_W-1:0]   eff_cnt;
  logic [PAGE_W-1:0]  ps_m1;
  logic [PAGE_W-1:0]  ps_mask;
  logic               accept;
  logic               issue;
  logic               scan_done;
  logic               seg_fail;
  logic               tail_fail;
  logic               past_end;
  logic               push;
  logic [LIM_W-1:0]   ep_plus1;
  logic [LIM_W-1:0]   next_wide;
  logic [LIM_W-1:0]   lim_calc;
  logic [LIM_W-1:0]   bound_up;
  logic [PAGE_W-1:0]  next_up;
  logic [PAGE_W-1:0]  query_page;
  logic [PAGE_W-1:0]  query_ep;

  logic      table_we;
  entry_t    table_wdata;
  entry_t    table_rdata;
  scan_ctl_t sctl;
  scan_res_t sres;

  always_comb begin
    if (page_shift < SHIFT_MIN) begin
      eff_shift = SHIFT_MIN;
    end else if (page_shift > SHIFT_MAX) begin
      eff_shift = SHIFT_MAX;
    end else begin
      eff_shift = page_shift;
    end
  end

  assign eff_cnt = (32'(region_count) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS)
                                                     : CNT_W'(region_count);
  assign ps_m1 = (PAGE_W'(1) << eff_shift) - PAGE_W'(1);
  assign ps_mask = ~ps_m1;

  assign req_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = req_valid && req_ready;

  assign query_page = {1'b0, query_addr} & ps_mask;
  assign query_ep = ({1'b0, query_addr} + PAGE_W'(query_length)) & ps_mask;

  assign issue = (state == ST_SCAN) && (issue_cnt < eff_cnt);
  assign scan_done = (state == ST_SCAN) && !issue && !rvalid;

  assign seg_fail = !sres.sel_valid || (key >= sres.sel_bound) ||
                    ((sres.sel_prot & need) == '0);
  assign ep_plus1 = {1'b0, ep} + LIM_W'(1);
  assign next_wide = LIM_W'(sres.next_base);
  assign lim_calc = (sres.has_next && (next_wide < ep_plus1)) ? next_wide : ep_plus1;
  assign bound_up = ({1'b0, sres.sel_bound} + {1'b0, ps_m1}) & {1'b1, ps_mask};
  assign tail_fail = ({1'b0, sres.sel_bound} < lim) && (bound_up < lim);
  assign next_up = ({1'b0, sres.next_base} + ps_m1) & ps_mask;
  assign past_end = key > ep;
  assign push = (state == ST_DONE) && (!rsp_valid || rsp_ready);

  assign table_we = accept && (req_t'(req_type) == REQ_LOAD) &&
                    (32'(entry_slot) < MAX_REGIONS);
  assign table_wdata = '{base: entry_start, bound: entry_end, prot: entry_prot};

  assign sctl.clear = (accept && (req_t'(req_type) != REQ_LOAD)) ||
                      ((state == ST_SEG_TEST) && !past_end);
  assign sctl.hit = rvalid;
  assign sctl.idx = ridx;

  rtpc_table u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (IDX_W'(entry_slot)),
    .wdata (table_wdata),
    .re    (issue),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (table_rdata)
  );

  rtpc_scan u_scan (
    .clk (clk),
    .rst (rst),
    .ctl (sctl),
    .ent (table_rdata),
    .key (key),
    .res (sres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req_t'(req_type) == REQ_LOAD) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = (rtype == REQ_RANGE) ? ST_SEG_CHECK : ST_DONE;
        end
      end
      ST_SEG_CHECK: begin
        state_next = seg_fail ? ST_DONE : ST_SEG_LIMIT;
      end
      ST_SEG_LIMIT: begin
        state_next = (tail_fail || !sres.has_next) ? ST_DONE : ST_SEG_NEXT;
      end
      ST_SEG_NEXT: begin
        state_next = ST_SEG_TEST;
      end
      ST_SEG_TEST: begin
        state_next = past_end ? ST_DONE : ST_SCAN;
      end
      ST_DONE: begin
        if (push) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift <= SHIFT_RESET;
      region_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PAGE_SHIFT: page_shift <= cfg_data[SHIFT_W-1:0];
        REG_REGION_COUNT: region_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= issue;
      if (sctl.clear) begin
        issue_cnt <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx <= issue_cnt[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          rtype <= req_t'(req_type);
          need <= required_prot;
          ep <= query_ep;
          key <= (req_t'(req_type) == REQ_FIND) ? {1'b0, query_addr} : query_page;
          res_ok <= 1'b0;
          res_prot <= '0;
          res_found <= 1'b0;
          res_idx <= '0;
        end
      end
      ST_SCAN: begin
        if (scan_done && (rtype == REQ_LOOKUP) && sres.sel_valid &&
            (key < sres.sel_bound)) begin
          res_prot <= sres.sel_prot;
        end
        if (scan_done && (rtype == REQ_FIND) && sres.found) begin
          res_found <= 1'b1;
          res_idx <= OUT_IDX_W'(sres.found_idx);
        end
      end
      ST_SEG_CHECK: begin
        lim <= lim_calc;
      end
      ST_SEG_LIMIT: begin
        if (!tail_fail && !sres.has_next) begin
          res_ok <= 1'b1;
        end
      end
      ST_SEG_NEXT: begin
        key <= next_up;
      end
      ST_SEG_TEST: begin
        if (past_end) begin
          res_ok <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      access_ok <= res_ok;
      page_prot <= res_prot;
      entry_found <= res_found;
      entry_index <= res_idx;
    end
  end

  `RTPC_ASSERT_NEXT(a_busy_after_accept, accept, !req_ready,
    "block still ready after accepting an item")
  `RTPC_ASSERT_NOW(a_issue_bounded, state == ST_SCAN, issue_cnt <= eff_cnt,
    "table walk ran past the region count")
  `RTPC_ASSERT_NOW(a_single_kind, rsp_valid && (page_prot != '0),
    !access_ok && !entry_found, "result carries more than one kind of answer")
  `RTPC_ASSERT_NOW(a_index_zero, rsp_valid && !entry_found, entry_index == '0,
    "index given without a containing region")

endmodule
